### sv/jtfle_pkg.sv
// Shared types, codes and byte helpers for the JSON text-field line extractor.
package jtfle_pkg;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_X     = 8'h78;

  localparam logic [2:0] KEY_LAST = 3'd5;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_COMMIT  = 2'd1,
    KIND_DISCARD = 2'd2
  } kind_t;

  typedef enum logic [6:0] {
    PH_SEARCH = 7'b0000001,
    PH_COLON  = 7'b0000010,
    PH_QUOTE  = 7'b0000100,
    PH_VALUE  = 7'b0001000,
    PH_ESCAPE = 7'b0010000,
    PH_CLOSED = 7'b0100000,
    PH_FAILED = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [7:0] ch;
  } jtfle_res_t;

  // Key is "text" with its quotes.
  function automatic logic [7:0] key_byte(input logic [2:0] p);
    logic [7:0] b;
    unique case (p)
      3'd0:    b = CH_QUOTE;
      3'd1:    b = CH_T;
      3'd2:    b = CH_E;
      3'd3:    b = CH_X;
      3'd4:    b = CH_T;
      3'd5:    b = CH_QUOTE;
      default: b = CH_QUOTE;
    endcase
    return b;
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

### sv/jtfle_parse.sv
// Line parser: phase and key-match state plus per-byte decode.
module jtfle_parse
  import jtfle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  output jtfle_res_t res
);

  phase_t     phase, phase_next;
  logic [2:0] key_progress, key_progress_next;
  logic [2:0] p;
  logic [7:0] dec;

  always_comb begin
    phase_next        = phase;
    key_progress_next = key_progress;
    res               = '0;
    p                 = (key_progress > KEY_LAST) ? 3'd0 : key_progress;
    dec               = in_byte;
    if (in_byte == CH_LF) begin
      res.vld           = 1'b1;
      res.kind          = (phase == PH_CLOSED) ? KIND_COMMIT : KIND_DISCARD;
      phase_next        = PH_SEARCH;
      key_progress_next = 3'd0;
    end else begin
      unique case (phase)
        PH_SEARCH: begin
          if (in_byte == key_byte(p)) begin
            if (p == KEY_LAST) begin
              phase_next        = PH_COLON;
              key_progress_next = 3'd0;
            end else begin
              key_progress_next = p + 3'd1;
            end
          end else begin
            // a quote can always restart the key
            key_progress_next = (in_byte == CH_QUOTE) ? 3'd1 : 3'd0;
          end
        end
        PH_COLON: begin
          if (!is_ws(in_byte)) phase_next = (in_byte == CH_COLON) ? PH_QUOTE : PH_FAILED;
        end
        PH_QUOTE: begin
          if (!is_ws(in_byte)) phase_next = (in_byte == CH_QUOTE) ? PH_VALUE : PH_FAILED;
        end
        PH_VALUE: begin
          if (in_byte == CH_QUOTE) begin
            phase_next = PH_CLOSED;
          end else if (in_byte == CH_BSL) begin
            phase_next = PH_ESCAPE;
          end else begin
            res.vld  = 1'b1;
            res.kind = KIND_CHAR;
            res.ch   = in_byte;
          end
        end
        PH_ESCAPE: begin
          priority if (in_byte == CH_N) dec = CH_LF;
          else if (in_byte == CH_R) dec = CH_CR;
          else if (in_byte == CH_T) dec = CH_TAB;
          else dec = in_byte;
          phase_next = PH_VALUE;
          res.vld    = 1'b1;
          res.kind   = KIND_CHAR;
          res.ch     = dec;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      key_progress <= 3'd0;
    end else if (step) begin
      phase        <= phase_next;
      key_progress <= key_progress_next;
    end
  end

endmodule

### sv/json_text_field_line_extractor.sv
// Top level: input register, line parser, output register.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_ready, in_byte      | sink
//  out     | out_valid, out_ready, kind,      | source
//          | out_char                         |
//
// One byte per cycle sustained while out does not stall; a result passes the input
// register and then the output register, where it is held until accepted.
// The parser state advances as a byte leaves the input register.
// Reset returns the parser to key search with nothing in flight.
// When out stalls, the input register holds and in_ready drops once it is full.
module json_text_field_line_extractor
  import jtfle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_char
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_adv;
  jtfle_res_t res;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  jtfle_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_adv),
    .in_byte (s1_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= in_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && res.vld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.vld) begin
      kind     <= res.kind;
      out_char <= res.ch;
    end
  end

endmodule

### sv/jtfle_checker.sv
// Port-level checker for the extractor, bound to the top level.
module jtfle_checker
  import jtfle_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_char
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_char))
    else $error("result changed while stalled");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_CHAR) || (kind == KIND_COMMIT) || (kind == KIND_DISCARD))
    else $error("illegal kind");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_CHAR) |-> out_char == 8'h00)
    else $error("status result with nonzero char");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // an LF taken with a free output path yields a line status after the input and output registers
  a_lf_status: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_byte == CH_LF) && out_ready ##1 out_ready |=>
      out_valid && (kind != KIND_CHAR))
    else $error("missing line status after LF");

endmodule

bind json_text_field_line_extractor jtfle_checker u_jtfle_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_byte   (in_byte),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_char  (out_char)
);
